### sv/vqfl_pkg.sv
// vqfl_pkg: shared types, codes and sizes for the virtqueue descriptor free list.
// No dependencies; used by virtqueue_descriptor_free_list, vqfl_engine and vqfl_checker.

package vqfl_pkg;

  localparam int NUM_RINGS = 4;
  localparam int QUEUE_MAX = 256;

  localparam int FUNC_W   = 3;
  localparam int RING_W   = 2;
  localparam int DESC_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int AVAIL_W  = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT        = 3'd0,
    FN_ALLOC_ONE   = 3'd1,
    FN_ALLOC_CHAIN = 3'd2,
    FN_FREE_ONE    = 3'd3,
    FN_FREE_CHAIN  = 3'd4,
    FN_SUBMIT      = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_SHORT = 2'd1,
    STS_BAD   = 2'd2
  } status_e;

  // one descriptor entry: chain flag and next link
  typedef struct packed {
    logic              flag;
    logic [DESC_W-1:0] link;
  } link_word_t;

  localparam int LINK_WORD_W = $bits(link_word_t);

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [RING_W-1:0]  ring;
    logic [DESC_W-1:0]  desc_id;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [DESC_W-1:0]  index;
    logic [COUNT_W-1:0] free_left;
    logic [AVAIL_W-1:0] avail_count;
  } res_t;

endpackage

### sv/virtqueue_descriptor_free_list.sv
// Channel  Dir  Signals                       Word
// s_axis   in   tvalid tready tdata tuser     one operation on one virtqueue
// m_axis   out  tvalid tready tdata tuser     one answer per operation
//
// Errors, submit and unused codes answer without the link memory; alloc one and
// free one do a link memory read, then the update; a chain or an init walks
// one descriptor per cycle through the link memory port.
// Reset clears the per-ring registers at once; the link memory needs no clear.
// The output register holds one answer, so a stalled m_axis holds at most
// one more word inside before s_axis stops.
// Depends on vqfl_pkg, vqfl_ram, vqfl_engine.

module virtqueue_descriptor_free_list #(
  parameter int NumRings = vqfl_pkg::NUM_RINGS,
  parameter int QueueMax = vqfl_pkg::QUEUE_MAX
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // ring[1:0], desc_id[9:2], count[18:10]
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // index[7:0], free_left[16:8], avail_count[32:17]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int Depth = NumRings * QueueMax;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WordW = vqfl_pkg::LINK_WORD_W;

  vqfl_pkg::cmd_t cmd;
  vqfl_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic           m_valid_q;
  vqfl_pkg::res_t m_data_q;

  assign cmd.func    = s_axis_tuser;
  assign cmd.ring    = s_axis_tdata[1:0];
  assign cmd.desc_id = s_axis_tdata[9:2];
  assign cmd.count   = s_axis_tdata[18:10];

  vqfl_engine #(
    .NumRings(NumRings),
    .QueueMax(QueueMax)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  vqfl_ram #(
    .Width(WordW),
    .Depth(Depth)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_data_q.status;
  assign m_axis_tdata  = {7'd0, m_data_q.avail_count, m_data_q.free_left, m_data_q.index};

endmodule

### sv/vqfl_ram.sv
// vqfl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module vqfl_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/vqfl_engine.sv
// vqfl_engine: per-ring free list registers and the sequencer that walks the
// descriptor link memory. Depends on vqfl_pkg; drives an external vqfl_ram.

module vqfl_engine #(
  parameter int NumRings = vqfl_pkg::NUM_RINGS,
  parameter int QueueMax = vqfl_pkg::QUEUE_MAX,
  localparam int Depth    = NumRings * QueueMax,
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int RingIdxW = (NumRings > 1) ? $clog2(NumRings) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  output logic                                 cmd_ready_o,
  input  vqfl_pkg::cmd_t                       cmd_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output vqfl_pkg::res_t                       res_o,
  output logic                                 ram_we_o,
  output logic [AddrW-1:0]                     ram_waddr_o,
  output logic [vqfl_pkg::LINK_WORD_W-1:0]     ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [AddrW-1:0]                     ram_raddr_o,
  input  logic [vqfl_pkg::LINK_WORD_W-1:0]     ram_rdata_i
);

  localparam int DW = vqfl_pkg::DESC_W;
  localparam int CW = vqfl_pkg::COUNT_W;
  localparam int AW = vqfl_pkg::AVAIL_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  function automatic logic [AddrW-1:0] mem_addr(input logic [RingIdxW-1:0] r,
                                                input logic [DW-1:0] d);
    mem_addr = AddrW'(r) * AddrW'(QueueMax) + AddrW'(d);
  endfunction

  // per-ring registers; heads are kept already masked
  logic [DW-1:0]     head_q   [NumRings];
  logic [DW-1:0]     head_d   [NumRings];
  logic [CW-1:0]     total_q  [NumRings];
  logic [CW-1:0]     total_d  [NumRings];
  logic [AW-1:0]     avail_q  [NumRings];
  logic [AW-1:0]     avail_d  [NumRings];
  logic [DW-1:0]     mask_q   [NumRings];
  logic [DW-1:0]     mask_d   [NumRings];
  logic [NumRings-1:0] active_q, active_d;

  logic [2:0]             state_q, state_d;
  vqfl_pkg::func_e        func_q, func_d;
  logic [RingIdxW-1:0]    ring_q, ring_d;
  logic                   in_range_q, in_range_d;
  logic [DW-1:0]          cur_q, cur_d;
  logic [CW-1:0]          left_q, left_d;
  logic [DW-1:0]          last_q, last_d;
  logic                   first_q, first_d;
  vqfl_pkg::status_e      status_q, status_d;
  logic [DW-1:0]          index_q, index_d;
  logic                   fwd_hit_q, fwd_hit_d;
  vqfl_pkg::link_word_t   fwd_word_q, fwd_word_d;

  // incoming command decode
  vqfl_pkg::func_e        c_func;
  logic                   c_in_rng;
  logic [RingIdxW-1:0]    ci;
  logic [DW-1:0]          c_mask;
  logic [CW-1:0]          c_total;
  logic [CW-1:0]          c_size;
  logic                   c_full;
  logic [DW-1:0]          c_d;
  logic [CW-1:0]          c_cnt;
  logic                   c_len_ok;
  logic                   c_known;

  // walk step values
  vqfl_pkg::link_word_t   rd_word;
  logic [DW-1:0]          w_mask;
  logic [DW-1:0]          w_nxt;
  logic [CW-1:0]          w_size;
  logic [CW-1:0]          w_tot_inc;

  logic                   we;
  logic [AddrW-1:0]       waddr;
  vqfl_pkg::link_word_t   wdata;
  logic                   re;
  logic [AddrW-1:0]       raddr;

  assign c_func   = vqfl_pkg::func_e'(cmd_i.func);
  assign c_in_rng = int'(cmd_i.ring) < NumRings;
  assign ci       = c_in_rng ? RingIdxW'(cmd_i.ring) : '0;
  assign c_mask   = mask_q[ci];
  assign c_total  = total_q[ci];
  assign c_size   = {1'b0, c_mask} + CW'(1);
  assign c_full   = c_total >= c_size;
  assign c_d      = cmd_i.desc_id & c_mask;
  assign c_cnt    = cmd_i.count;
  assign c_len_ok = (c_cnt != '0) && ((c_cnt & (c_cnt - CW'(1))) == '0)
                    && (int'(c_cnt) <= QueueMax);
  assign c_known  = cmd_i.func <= vqfl_pkg::FUNC_W'(vqfl_pkg::FN_SUBMIT);

  // a read issued together with a write to the same entry takes the new word
  assign rd_word   = fwd_hit_q ? fwd_word_q : vqfl_pkg::link_word_t'(ram_rdata_i);
  assign w_mask    = mask_q[ring_q];
  assign w_nxt     = rd_word.link & w_mask;
  assign w_size    = {1'b0, w_mask} + CW'(1);
  assign w_tot_inc = total_q[ring_q] + CW'(1);

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    ring_d     = ring_q;
    in_range_d = in_range_q;
    cur_d      = cur_q;
    left_d     = left_q;
    last_d     = last_q;
    first_d    = first_q;
    status_d   = status_q;
    index_d    = index_q;
    head_d     = head_q;
    total_d    = total_q;
    avail_d    = avail_q;
    mask_d     = mask_q;
    active_d   = active_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          func_d     = c_func;
          ring_d     = ci;
          in_range_d = c_in_rng;
          status_d   = vqfl_pkg::STS_OK;
          index_d    = '0;
          first_d    = 1'b1;
          state_d    = ST_DONE;
          if (!c_in_rng) begin
            status_d = vqfl_pkg::STS_BAD;
          end else if (c_func == vqfl_pkg::FN_INIT) begin
            if (!c_len_ok) begin
              status_d = vqfl_pkg::STS_BAD;
            end else begin
              // registers settle now, the link walk follows
              mask_d[ci]   = DW'(c_cnt - CW'(1));
              head_d[ci]   = DW'(c_cnt - CW'(1));
              total_d[ci]  = c_cnt;
              avail_d[ci]  = '0;
              active_d[ci] = 1'b1;
              cur_d        = '0;
              left_d       = c_cnt;
              state_d      = ST_INIT;
            end
          end else if (c_known && !active_q[ci]) begin
            status_d = vqfl_pkg::STS_BAD;
          end else begin
            unique case (c_func)
              vqfl_pkg::FN_ALLOC_ONE: begin
                if (c_total == '0) begin
                  status_d = vqfl_pkg::STS_SHORT;
                end else begin
                  re      = 1'b1;
                  raddr   = mem_addr(ci, head_q[ci]);
                  cur_d   = head_q[ci];
                  state_d = ST_WALK;
                end
              end
              vqfl_pkg::FN_ALLOC_CHAIN: begin
                if (c_cnt == '0 || c_cnt > c_total) begin
                  status_d = vqfl_pkg::STS_SHORT;
                end else begin
                  re      = 1'b1;
                  raddr   = mem_addr(ci, head_q[ci]);
                  cur_d   = head_q[ci];
                  left_d  = c_cnt;
                  state_d = ST_WALK;
                end
              end
              vqfl_pkg::FN_FREE_ONE: begin
                if (c_full) begin
                  status_d = vqfl_pkg::STS_SHORT;
                end else begin
                  re      = 1'b1;
                  raddr   = mem_addr(ci, c_d);
                  cur_d   = c_d;
                  state_d = ST_WALK;
                end
              end
              vqfl_pkg::FN_FREE_CHAIN: begin
                if (c_full) begin
                  status_d = vqfl_pkg::STS_SHORT;
                end else begin
                  re      = 1'b1;
                  raddr   = mem_addr(ci, c_d);
                  cur_d   = c_d;
                  left_d  = c_size;
                  state_d = ST_WALK;
                end
              end
              vqfl_pkg::FN_SUBMIT: begin
                avail_d[ci] = avail_q[ci] + AW'(1);
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_INIT: begin
        // descriptor i links to i-1, chain flag cleared; descriptor 0 was
        // pushed onto an empty list and keeps the low bits of the empty marker
        we      = 1'b1;
        waddr   = mem_addr(ring_q, cur_q);
        wdata   = '{flag: 1'b0,
                    link: (cur_q == '0) ? DW'(QueueMax) : cur_q - DW'(1)};
        cur_d   = cur_q + DW'(1);
        left_d  = left_q - CW'(1);
        if (left_q == CW'(1)) begin
          state_d = ST_DONE;
        end
      end

      ST_WALK: begin
        unique case (func_q)
          vqfl_pkg::FN_ALLOC_ONE: begin
            head_d[ring_q]  = w_nxt;
            total_d[ring_q] = total_q[ring_q] - CW'(1);
            index_d         = cur_q;
            state_d         = ST_DONE;
          end
          vqfl_pkg::FN_ALLOC_CHAIN: begin
            we              = 1'b1;
            waddr           = mem_addr(ring_q, cur_q);
            wdata           = '{flag: !first_q, link: first_q ? '0 : last_q};
            last_d          = cur_q;
            first_d         = 1'b0;
            head_d[ring_q]  = w_nxt;
            total_d[ring_q] = total_q[ring_q] - CW'(1);
            left_d          = left_q - CW'(1);
            if (left_q == CW'(1)) begin
              index_d = cur_q;
              state_d = ST_DONE;
            end else begin
              re    = 1'b1;
              raddr = mem_addr(ring_q, w_nxt);
              cur_d = w_nxt;
            end
          end
          vqfl_pkg::FN_FREE_ONE: begin
            we              = 1'b1;
            waddr           = mem_addr(ring_q, cur_q);
            wdata           = '{flag: rd_word.flag, link: head_q[ring_q]};
            head_d[ring_q]  = cur_q;
            total_d[ring_q] = w_tot_inc;
            state_d         = ST_DONE;
          end
          vqfl_pkg::FN_FREE_CHAIN: begin
            we              = 1'b1;
            waddr           = mem_addr(ring_q, cur_q);
            wdata           = '{flag: rd_word.flag, link: head_q[ring_q]};
            head_d[ring_q]  = cur_q;
            total_d[ring_q] = w_tot_inc;
            left_d          = left_q - CW'(1);
            if (!rd_word.flag || left_q == CW'(1)) begin
              state_d = ST_DONE;
            end else if (w_tot_inc >= w_size) begin
              // chain continues onto a full list
              status_d = vqfl_pkg::STS_SHORT;
              state_d  = ST_DONE;
            end else begin
              re    = 1'b1;
              raddr = mem_addr(ring_q, w_nxt);
              cur_d = w_nxt;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    fwd_hit_d  = we && re && (waddr == raddr);
    fwd_word_d = wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fwd_hit_q  <= 1'b0;
      active_q   <= '0;
      for (int r = 0; r < NumRings; r++) begin
        head_q[r]  <= '0;
        total_q[r] <= '0;
        avail_q[r] <= '0;
        mask_q[r]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      fwd_hit_q <= fwd_hit_d;
      active_q  <= active_d;
      head_q    <= head_d;
      total_q   <= total_d;
      avail_q   <= avail_d;
      mask_q    <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    ring_q     <= ring_d;
    in_range_q <= in_range_d;
    cur_q      <= cur_d;
    left_q     <= left_d;
    last_q     <= last_d;
    first_q    <= first_d;
    status_q   <= status_d;
    index_q    <= index_d;
    fwd_word_q <= fwd_word_d;
  end

  assign cmd_ready_o = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;

  assign res_o.status      = status_q;
  assign res_o.index       = index_q;
  assign res_o.free_left   = in_range_q ? total_q[ring_q] : '0;
  assign res_o.avail_count = in_range_q ? avail_q[ring_q] : '0;

  assign ram_we_o    = we;
  assign ram_waddr_o = waddr;
  assign ram_wdata_o = wdata;
  assign ram_re_o    = re;
  assign ram_raddr_o = raddr;

endmodule

### sv/vqfl_checker.sv
// vqfl_checker: port-level assertions for the descriptor free list, bound to
// the top level. Depends on virtqueue_descriptor_free_list and vqfl_pkg.

module vqfl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled answer word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("answer word changed while stalled");

  // one operation at a time: ready drops right after a word is taken
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while an operation is in progress");

  // index is only reported on a successful operation
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != vqfl_pkg::STATUS_W'(vqfl_pkg::STS_OK)) |->
      m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero index with error status");

  // free count never exceeds the largest ring
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> int'(m_axis_tdata[16:8]) <= vqfl_pkg::QUEUE_MAX)
    else $error("free count above ring capacity");

endmodule

bind virtqueue_descriptor_free_list vqfl_checker u_vqfl_checker (.*);
